/* hdl/xor_checked_frame_deframer_defines.svh */
// Assertion macros for the deframer RTL, used by the parser (xcfd_parse).
`ifndef XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define XCFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("xcfd assertion failed");

// Next-cycle implication, disabled during reset
`define XCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("xcfd assertion failed");

`else

`define XCFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define XCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/xcfd_pkg.sv */
// Types and constants shared by the frame deframer modules.
package xcfd_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h7E;
	localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_BYTE = 1'b0,
		CFG_MAX_PAYLOAD = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LENGTH = 3'd1,
		PH_TYPE = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BADSUM = 2'd1,
		ST_BADLEN = 2'd2
	} status_t;

	typedef struct packed {
		logic is_end;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] frame_type;
		status_t status;
	} res_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] max_payload;
	} cfg_t;

endpackage

/* hdl/xcfd_in_stage.sv */
// Input register stage: holds one received word until the parser takes it.
module xcfd_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [xcfd_pkg::BYTE_W-1:0] in_byte,
	input  logic                      advance,
	output logic                      valid_s1,
	output logic [xcfd_pkg::BYTE_W-1:0] byte_s1
);

	// Take a new word when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

/* hdl/xcfd_parse.sv */
// Frame parser: phase state, checksum and the result register.
`include "xor_checked_frame_deframer_defines.svh"

module xcfd_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  xcfd_pkg::cfg_t            cfg,
	input  logic                      valid_s1,
	input  logic [xcfd_pkg::BYTE_W-1:0] byte_s1,
	output logic                      advance,
	output logic                      out_valid,
	input  logic                      out_ready,
	output xcfd_pkg::res_t            res
);

	xcfd_pkg::phase_t phase_q, phase_d;
	logic [xcfd_pkg::BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [xcfd_pkg::BYTE_W-1:0] running_xor_q, running_xor_d;
	logic [xcfd_pkg::BYTE_W-1:0] held_type_q, held_type_d;
	logic [xcfd_pkg::BYTE_W-1:0] left_dec;
	logic                      res_valid;
	xcfd_pkg::res_t            res_d;
	logic                      pop;

	// Result register frees up when empty or being taken
	assign advance = !out_valid || out_ready;
	assign pop = valid_s1 && advance;
	assign left_dec = bytes_left_q - 8'd1;

	// Next state
	always_comb begin
		phase_d = phase_q;
		bytes_left_d = bytes_left_q;
		running_xor_d = running_xor_q;
		held_type_d = held_type_q;
		unique case (phase_q)
			xcfd_pkg::PH_LENGTH: begin
				if (byte_s1 == '0 || byte_s1 > cfg.max_payload) begin
					phase_d = xcfd_pkg::PH_HUNT;
					bytes_left_d = '0;
				end else begin
					bytes_left_d = byte_s1;
					phase_d = xcfd_pkg::PH_TYPE;
				end
			end
			xcfd_pkg::PH_TYPE: begin
				held_type_d = byte_s1;
				running_xor_d = byte_s1;
				phase_d = xcfd_pkg::PH_PAYLOAD;
			end
			xcfd_pkg::PH_PAYLOAD: begin
				running_xor_d = running_xor_q ^ byte_s1;
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = xcfd_pkg::PH_CHECK;
				end
			end
			xcfd_pkg::PH_CHECK: begin
				phase_d = xcfd_pkg::PH_HUNT;
			end
			default: begin
				phase_d = xcfd_pkg::PH_HUNT;
				if (byte_s1 == cfg.start_byte) begin
					held_type_d = '0;
					running_xor_d = '0;
					bytes_left_d = '0;
					phase_d = xcfd_pkg::PH_LENGTH;
				end
			end
		endcase
	end

	// Result for the word in the input stage
	always_comb begin
		res_valid = 1'b0;
		res_d = '{is_end: 1'b0, data: '0, frame_type: '0, status: xcfd_pkg::ST_OK};
		unique case (phase_q)
			xcfd_pkg::PH_LENGTH: begin
				if (byte_s1 == '0 || byte_s1 > cfg.max_payload) begin
					res_valid = 1'b1;
					res_d.is_end = 1'b1;
					res_d.status = xcfd_pkg::ST_BADLEN;
				end
			end
			xcfd_pkg::PH_PAYLOAD: begin
				res_valid = 1'b1;
				res_d.data = byte_s1;
				res_d.frame_type = held_type_q;
			end
			xcfd_pkg::PH_CHECK: begin
				res_valid = 1'b1;
				res_d.is_end = 1'b1;
				res_d.frame_type = held_type_q;
				res_d.status = (running_xor_q == byte_s1) ? xcfd_pkg::ST_OK
					: xcfd_pkg::ST_BADSUM;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// Advance parse state on each consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xcfd_pkg::PH_HUNT;
			bytes_left_q <= '0;
			running_xor_q <= '0;
			held_type_q <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			bytes_left_q <= bytes_left_d;
			running_xor_q <= running_xor_d;
			held_type_q <= held_type_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= pop && res_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			res <= res_d;
		end
	end

	`XCFD_ASSERT_IMPLY(a_payload_count, clk, arst_n, phase_q == xcfd_pkg::PH_PAYLOAD, bytes_left_q != '0)
	`XCFD_ASSERT_NEXT(a_check_to_hunt, clk, arst_n, pop && phase_q == xcfd_pkg::PH_CHECK, phase_q == xcfd_pkg::PH_HUNT)
	`XCFD_ASSERT_IMPLY(a_payload_status, clk, arst_n, out_valid && !res.is_end, res.status == xcfd_pkg::ST_OK)
	`XCFD_ASSERT_IMPLY(a_badlen_clean, clk, arst_n, out_valid && res.status == xcfd_pkg::ST_BADLEN, res.is_end && res.frame_type == '0 && res.data == '0)

endmodule

/* hdl/xor_checked_frame_deframer.sv */
// Top level of the length-prefixed frame deframer with XOR checksum.

// Takes one stream word per cycle while out_ready stays high: a word accepted on
// in_valid/in_ready sits in the input register, is parsed by the combinational phase
// logic and lands in the result register, from which its result is presented. Frames
// are start byte, length, type, payload and an XOR checksum over type and payload; each
// payload word comes out with the frame type, and the checksum word yields one end
// result (ok or bad checksum). A length of zero or above max_payload yields a
// bad-length end result and hunting resumes at the next word.
// Write start_byte and max_payload through cfg_we/cfg_index/cfg_data only while idle.
module xor_checked_frame_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [xcfd_pkg::BYTE_W-1:0]    in_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         is_end,
	output logic [xcfd_pkg::BYTE_W-1:0]    data,
	output logic [xcfd_pkg::BYTE_W-1:0]    frame_type,
	output logic [1:0]                   status,
	input  logic                         cfg_we,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xcfd_pkg::BYTE_W-1:0]    cfg_data
);

	xcfd_pkg::cfg_t cfg_q;
	xcfd_pkg::res_t res;
	logic           advance;
	logic           valid_s1;
	logic [xcfd_pkg::BYTE_W-1:0] byte_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= xcfd_pkg::START_BYTE_RST;
			cfg_q.max_payload <= xcfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			unique case (xcfd_pkg::cfg_idx_t'(cfg_index))
				xcfd_pkg::CFG_START_BYTE: cfg_q.start_byte <= cfg_data;
				xcfd_pkg::CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	xcfd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	xcfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// Break out result fields
	assign is_end = res.is_end;
	assign data = res.data;
	assign frame_type = res.frame_type;
	assign status = res.status;

endmodule
